// ===== sv/interval_table_huffman_decoder_unit_defines.svh =====
// Assertion macros used by the decoder checker.
`ifndef INTERVAL_TABLE_HUFFMAN_DECODER_UNIT_DEFINES_SVH
`define INTERVAL_TABLE_HUFFMAN_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ITD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ITD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/itd_pkg.sv =====
// ---------------------------------------------------------------------------
// itd_pkg
// Types and constants shared by the interval-table Huffman decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package itd_pkg;

   localparam int TABLE_DEPTH_DEF   = 256;
   localparam int MAX_PEEK_BITS_DEF = 13;
   localparam int CODE_W            = 16;  // widest peek code in range
   localparam int WIN_W             = 24;
   localparam int FILL_W            = 5;

   // Item kinds on the request channel
   localparam logic [1:0] MODE_TABLE = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_BYTE  = 2'd2;

   // Register indexes on the csr channel
   localparam logic [1:0] REG_TABLE_SEL = 2'd0;
   localparam logic [1:0] REG_SMALL_CNT = 2'd1;
   localparam logic [1:0] REG_LARGE_CNT = 2'd2;

   // Lookup query travelling along the cell row
   typedef struct packed {
      logic              valid;
      logic              done;
      logic [CODE_W-1:0] code;
      logic [7:0]        ch;
      logic [3:0]        len;
   } query_type;

   // Table entry write broadcast to all cells
   typedef struct packed {
      logic        valid;
      logic        table_id;
      logic [7:0]  index;
      logic [12:0] start;
      logic [7:0]  ch;
      logic [3:0]  len;
   } entry_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_EMIT,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

// ===== sv/itd_cell.sv =====
// ---------------------------------------------------------------------------
// itd_cell
// One table position for both tables; refines the passing lookup query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module itd_cell import itd_pkg::*; #(
   parameter int CELL_IDX = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire entry_wr_type wr,
   input  wire logic         table_sel,
   input  wire logic [8:0]   entries_used,
   input  wire query_type    query_in,
   output      query_type    query_out
);

   logic [12:0] start_ff [2];
   logic [7:0]  char_ff  [2];
   logic [3:0]  len_ff   [2];
   query_type   query_ff;
   query_type   query_in_next;
   logic        in_use;
   logic        fits;

   // Entry storage, written by index match
   always_ff @(posedge clock) begin
      if (wr.valid && (int'(wr.index) == CELL_IDX)) begin
         start_ff[wr.table_id] <= wr.start;
         char_ff[wr.table_id]  <= wr.ch;
         len_ff[wr.table_id]   <= wr.len;
      end
   end

   // Compare this entry against the code
   always_comb begin
      in_use = (CELL_IDX < int'(entries_used));
      fits   = (CODE_W'(start_ff[table_sel]) <= query_in.code);
      query_in_next = query_in;
      if (CELL_IDX == 0) begin
         // first entry is taken even if its start lies above the code
         query_in_next.ch   = char_ff[table_sel];
         query_in_next.len  = len_ff[table_sel];
         query_in_next.done = !fits;
      end else if (!query_in.done && in_use && fits) begin
         query_in_next.ch   = char_ff[table_sel];
         query_in_next.len  = len_ff[table_sel];
      end else begin
         query_in_next.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in_next;
      end
   end

   assign query_out = query_ff;

endmodule
`default_nettype wire

// ===== sv/itd_chain.sv =====
// ---------------------------------------------------------------------------
// itd_chain
// Row of table cells; a query hops one cell per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module itd_chain import itd_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire entry_wr_type wr,
   input  wire logic         table_sel,
   input  wire logic [8:0]   entries_used,
   input  wire query_type    query_in,
   output      query_type    query_out
);

   query_type link [TABLE_DEPTH+1];

   assign link[0] = query_in;

   // Cell row
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      itd_cell #(.CELL_IDX(i)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr           (wr),
         .table_sel    (table_sel),
         .entries_used (entries_used),
         .query_in     (link[i]),
         .query_out    (link[i+1])
      );
   end

   assign query_out = link[TABLE_DEPTH];

endmodule
`default_nettype wire

// ===== sv/interval_table_huffman_decoder_unit.sv =====
// Each symbol's query passes through every cell of the row, then the sequencer
// emits it from ST_EMIT; a byte goes through ST_CHECK before each search.
// Requests are taken one at a time, only in ST_IDLE; csr writes are always accepted.
// The cell row search length sets the symbol rate; a stalled result holds the sequencer.
// Reset: synchronous, active high; clears control, csr registers and the bit window.
// Table entries are undefined until written.
// ---------------------------------------------------------------------------
// interval_table_huffman_decoder_unit
// Huffman text decoder with interval tables held in a row of search cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module interval_table_huffman_decoder_unit import itd_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int MAX_PEEK_BITS = MAX_PEEK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // which_table[0], entry_index[8:1], entry_start[21:9], entry_char[29:22],
   // entry_length[33:30], decoded_length[41:34], data_byte[49:42], zero above
   input  wire logic [55:0] req_tdata,
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   input  wire logic        req_tlast,  // byte_last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,  // out_char[7:0]
   output      logic        rsp_tuser,  // no_symbol
   output      logic        rsp_tlast,  // end_of_text
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   localparam int EXT_W = WIN_W + MAX_PEEK_BITS;

   state_type state_ff, state_in;

   logic              sel_ff;
   logic [8:0]        small_cnt_ff, large_cnt_ff;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        emitted_ff, emitted_in;
   logic [7:0]        limit_ff, limit_in;
   logic              active_ff, active_in;
   logic              last_ff, last_in;
   logic              any_ff, any_in;
   logic [7:0]        ch_ff, ch_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic              out_nosym_ff, out_nosym_in;
   logic              out_end_ff, out_end_in;

   entry_wr_type      wr;
   query_type         q_launch, q_result;
   logic [8:0]        cnt_raw, cnt_use;
   logic [EXT_W-1:0]  ext_win, shifted;
   logic [CODE_W-1:0] peek_code;
   logic [FILL_W-1:0] need, len_c;
   logic              accept, slot_free, more;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         small_cnt_ff <= 9'd128;
         large_cnt_ff <= 9'd255;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TABLE_SEL: sel_ff       <= csr_data[0];
            REG_SMALL_CNT: small_cnt_ff <= csr_data;
            REG_LARGE_CNT: large_cnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Entry count clamped to 1..TABLE_DEPTH
   always_comb begin
      cnt_raw = sel_ff ? large_cnt_ff : small_cnt_ff;
      if (cnt_raw == 9'd0) begin
         cnt_use = 9'd1;
      end else if (int'(cnt_raw) > TABLE_DEPTH) begin
         cnt_use = 9'(TABLE_DEPTH);
      end else begin
         cnt_use = cnt_raw;
      end
   end

   // Table writes straight from the request item
   always_comb begin
      wr.valid    = accept && (req_tuser == MODE_TABLE) && (int'(req_tdata[8:1]) < TABLE_DEPTH);
      wr.table_id = req_tdata[0];
      wr.index    = req_tdata[8:1];
      wr.start    = req_tdata[21:9];
      wr.ch       = req_tdata[29:22];
      wr.len      = req_tdata[33:30];
   end

   // Zero-padded peek of the top bits of the window
   always_comb begin
      ext_win   = sel_ff ? {win_ff, {MAX_PEEK_BITS{1'b0}}}
                         : {2'b00, win_ff, {(MAX_PEEK_BITS-2){1'b0}}};
      shifted   = ext_win >> fill_ff;
      peek_code = CODE_W'(shifted[MAX_PEEK_BITS-1:0]);
      need      = last_ff ? FILL_W'(2) : FILL_W'(MAX_PEEK_BITS);
      more      = (emitted_ff < limit_ff) && (fill_ff >= need);
      q_launch       = '0;
      q_launch.valid = (state_ff == ST_CHECK) && more;
      q_launch.code  = peek_code;
   end

   itd_chain #(.TABLE_DEPTH(TABLE_DEPTH)) u_chain (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .table_sel    (sel_ff),
      .entries_used (cnt_use),
      .query_in     (q_launch),
      .query_out    (q_result)
   );

   // Code length clamped to 1..MAX_PEEK_BITS
   always_comb begin
      if (q_result.len == 4'd0) begin
         len_c = FILL_W'(1);
      end else if (int'(q_result.len) > MAX_PEEK_BITS) begin
         len_c = FILL_W'(MAX_PEEK_BITS);
      end else begin
         len_c = FILL_W'(q_result.len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= '0;
         fill_ff      <= '0;
         emitted_ff   <= '0;
         limit_ff     <= '0;
         active_ff    <= 1'b0;
         last_ff      <= 1'b0;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         emitted_ff   <= emitted_in;
         limit_ff     <= limit_in;
         active_ff    <= active_in;
         last_ff      <= last_in;
         any_ff       <= any_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      out_char_ff  <= out_char_in;
      out_nosym_ff <= out_nosym_in;
      out_end_ff   <= out_end_in;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      emitted_in   = emitted_ff;
      limit_in     = limit_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      any_in       = any_ff;
      ch_in        = ch_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_nosym_in = out_nosym_ff;
      out_end_in   = out_end_ff;
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == MODE_START) begin
                  limit_in   = req_tdata[41:34];
                  emitted_in = '0;
                  win_in     = '0;
                  fill_in    = '0;
                  active_in  = 1'b1;
               end else if ((req_tuser == MODE_BYTE) && active_ff) begin
                  win_in   = {win_ff[WIN_W-9:0], req_tdata[49:42]};
                  fill_in  = fill_ff + FILL_W'(8);
                  last_in  = req_tlast;
                  any_in   = 1'b0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = more ? ST_SEARCH : ST_FINISH;
         end
         ST_SEARCH: begin
            if (q_result.valid) begin
               ch_in      = q_result.ch;
               emitted_in = emitted_ff + 8'd1;
               any_in     = 1'b1;
               if (len_c >= fill_ff) begin
                  win_in  = '0;
                  fill_in = '0;
               end else begin
                  fill_in = fill_ff - len_c;
                  win_in  = win_ff & ~({WIN_W{1'b1}} << (fill_ff - len_c));
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ch_ff;
               out_nosym_in = 1'b0;
               out_end_in   = last_ff && !more;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               if (emitted_ff >= limit_ff) begin
                  win_in  = '0;
                  fill_in = '0;
               end
               state_in = ST_IDLE;
            end else if (any_ff || slot_free) begin
               if (!any_ff) begin
                  // end marker with no character
                  out_valid_in = 1'b1;
                  out_char_in  = 8'd0;
                  out_nosym_in = 1'b1;
                  out_end_in   = 1'b1;
               end
               win_in    = '0;
               fill_in   = '0;
               active_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_nosym_ff;
   assign rsp_tlast  = out_end_ff;

endmodule
`default_nettype wire

// ===== sv/itd_checker.sv =====
// ---------------------------------------------------------------------------
// itd_checker
// Port-level checks on the decoder's result channel and request ready, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "interval_table_huffman_decoder_unit_defines.svh"
module itd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   // a stalled result stays offered
   `ITD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // a no-symbol result is always the end marker with a zero character
   `ITD_ASSERT_NOW(a_nosym_end, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == 8'd0), "bad no-symbol item")

   // reset leaves no result pending and the block ready
   `ITD_ASSERT_NOW(a_reset_clear, $past(reset), !rsp_tvalid && req_tready, "state not cleared by reset")

endmodule

bind interval_table_huffman_decoder_unit itd_checker u_itd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== tb/sv/tb_interval_table_huffman_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// tb_interval_table_huffman_decoder_unit
// Self-checking bench for the interval-table Huffman decoder. Both tables are
// loaded in full first, so every lookup hits a written entry. A short directed
// table and then random texts follow. A local decoder model predicts each
// result, and each result is checked against the model in order. The run steps
// through several table and entry-count settings and several idle patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_interval_table_huffman_decoder_unit;
   import itd_pkg::*;

   localparam int DEPTH = 256;
   localparam int PEEK_MAX = 13;

   typedef struct {
      logic [1:0]  mode;
      logic        wt;
      logic [7:0]  idx;
      logic [12:0] st;
      logic [7:0]  ch;
      logic [3:0]  ln;
      logic [7:0]  dl;
      logic [7:0]  db;
      logic        last;
   } item_t;

   typedef struct {
      logic [7:0] ch;
      logic       nosym;
      logic       eot;
   } sym_t;

   typedef struct {
      item_t it;
      bit    nosym_end;  // typed expectation: one no-symbol end marker
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   // decoder model state
   logic [12:0] tab_start [2][DEPTH];
   logic [7:0]  tab_char [2][DEPTH];
   logic [3:0]  tab_len [2][DEPTH];
   logic        sel_large;
   logic [8:0]  small_cnt, large_cnt;
   logic [31:0] window, fill, emitted, limit;
   logic        active;

   sym_t symbols_due[$];
   int   errors = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_off = 0;

   interval_table_huffman_decoder_unit dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   initial begin
      #300ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Interval search over the active table
   task automatic lookup(input logic [31:0] code, output logic [7:0] c,
                         output logic [31:0] len);
      int t, n, i;
      t = sel_large;
      n = t ? large_cnt : small_cnt;
      i = 0;
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      while (i < n && tab_start[t][i] <= code) i++;
      if (i > 0) i--;
      c = tab_char[t][i];
      len = tab_len[t][i];
      if (len < 1) len = 1;
      if (len > PEEK_MAX) len = PEEK_MAX;
   endtask

   // Advance the model by one item; append the symbols it yields
   task automatic decode_item(input item_t it, ref sym_t res[$]);
      logic [31:0] need, w, code, len;
      logic [7:0]  c;
      sym_t        s;
      res = {};
      case (it.mode)
         MODE_TABLE: begin
            tab_start[it.wt][it.idx] = it.st;
            tab_char[it.wt][it.idx] = it.ch;
            tab_len[it.wt][it.idx] = it.ln;
         end
         MODE_START: begin
            limit = it.dl;
            emitted = 0;
            window = 0;
            fill = 0;
            active = 1'b1;
         end
         MODE_BYTE: if (active) begin
            need = it.last ? 2 : PEEK_MAX;
            w = sel_large ? PEEK_MAX : PEEK_MAX - 2;
            window = ((window << 8) | it.db) & 32'hFF_FFFF;
            fill += 8;
            while (emitted < limit && fill >= need) begin
               // zero-padded peek past the end of the window
               if (fill >= w) code = (window >> (fill - w)) & ((1 << w) - 1);
               else code = (window << (w - fill)) & ((1 << w) - 1);
               lookup(code, c, len);
               s.ch = c; s.nosym = 1'b0; s.eot = 1'b0;
               res.push_back(s);
               emitted++;
               if (len >= fill) begin
                  window = 0; fill = 0;
               end else begin
                  fill -= len;
                  window &= (1 << fill) - 1;
               end
            end
            if (emitted >= limit) begin
               window = 0; fill = 0;
            end
            if (it.last) begin
               if (res.size() > 0) res[res.size()-1].eot = 1'b1;
               else begin
                  s.ch = 8'h00; s.nosym = 1'b1; s.eot = 1'b1;
                  res.push_back(s);
               end
               window = 0; fill = 0;
               active = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // Drive one item and wait for its handshake
   task automatic send_item(input item_t it, input bit typed_end);
      sym_t res[$];
      sym_t s;
      @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tlast <= it.last;
      req_tdata <= {6'b0, it.db, it.dl, it.ln, it.ch, it.st, it.idx, it.wt};
      decode_item(it, res);
      if (typed_end) begin
         s.ch = 8'h00; s.nosym = 1'b1; s.eot = 1'b1;
         res = {s};
      end
      foreach (res[k]) symbols_due.push_back(res[k]);
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
   endtask

   function automatic item_t rand_item(logic [1:0] mode);
      item_t it;
      it.mode = mode;
      it.wt = $urandom_range(1);
      it.idx = $urandom_range(255);
      it.st = $urandom_range(8191);
      it.ch = $urandom_range(255);
      it.ln = $urandom_range(15);
      it.dl = $urandom_range(255);
      it.db = $urandom_range(255);
      it.last = $urandom_range(1);
      return it;
   endfunction

   task automatic write_csr(input logic [1:0] index, input logic [8:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_TABLE_SEL: sel_large = value[0];
         REG_SMALL_CNT: small_cnt = value;
         REG_LARGE_CNT: large_cnt = value;
         default: ;
      endcase
   endtask

   // Drain all results, then let a byte with no result finish its search
   task automatic settle();
      while (symbols_due.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   // Fill one table with non-decreasing starts; entry 0 may start above zero
   task automatic load_table(input logic t);
      item_t it;
      int s;
      s = $urandom_range(40);
      for (int i = 0; i < DEPTH; i++) begin
         it = rand_item(MODE_TABLE);
         it.wt = t;
         it.idx = i;
         it.st = (s > 8191) ? 13'h1FFF : s[12:0];
         send_item(it, 1'b0);
         s += $urandom_range(63);
      end
   endtask

   // One text: start, a few bytes, last byte; sometimes broken or noisy
   task automatic random_text(ref int sent);
      item_t it;
      int nb;
      it = rand_item(MODE_START);
      case ($urandom_range(9))
         0: it.dl = 0;
         1: it.dl = 255;
         2, 3: it.dl = $urandom_range(1, 3);
         default: it.dl = $urandom_range(1, 30);
      endcase
      send_item(it, 1'b0); sent++;
      nb = $urandom_range(1, 6);
      for (int b = 0; b < nb; b++) begin
         it = rand_item(MODE_BYTE);
         it.last = (b == nb - 1);
         case ($urandom_range(19))
            0: it.mode = 2'd3;
            1: it = rand_item(MODE_TABLE);
            2: begin
               it.mode = MODE_START;
               it.dl = $urandom_range(1, 20);
            end
            default: ;
         endcase
         send_item(it, 1'b0); sent++;
      end
      // stray byte while idle now and then
      if ($urandom_range(7) == 0) begin
         send_item(rand_item(MODE_BYTE), 1'b0); sent++;
      end
   endtask

   // Result checking and ready generation
   always @(posedge clock) begin
      sym_t e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (symbols_due.size() == 0) begin
               $display("%0t: unexpected result char %h nosym %b end %b",
                        $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               e = symbols_due.pop_front();
               if (rsp_tdata !== e.ch || rsp_tuser !== e.nosym || rsp_tlast !== e.eot) begin
                  $display("%0t: mismatch exp char %h nosym %b end %b, got %h %b %b",
                           $realtime, e.ch, e.nosym, e.eot, rsp_tdata, rsp_tuser, rsp_tlast);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      row_t dir[$];
      item_t it;
      int sent;
      int idle_set [4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{27, 27}};
      logic [8:0] counts [5][3] = '{
         '{9'd1, 9'd128, 9'd255}, '{9'd0, 9'd256, 9'd1}, '{9'd1, 9'd511, 9'd256},
         '{9'd0, 9'd257, 9'd0}, '{9'd1, 9'd200, 9'd100}};

      sel_large = 1'b0; small_cnt = 128; large_cnt = 255;
      window = 0; fill = 0; emitted = 0; limit = 0; active = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      load_table(1'b0);
      load_table(1'b1);

      // Directed part
      it = rand_item(MODE_START); it.dl = 0; dir.push_back('{it, 0});
      it = rand_item(MODE_BYTE); it.db = 8'hA5; it.last = 1; dir.push_back('{it, 1});
      it = rand_item(MODE_BYTE); it.last = 1; dir.push_back('{it, 0});      // idle
      it = rand_item(2'd3); dir.push_back('{it, 0});                         // mode 3
      it = rand_item(MODE_START); it.dl = 255; dir.push_back('{it, 0});
      it = rand_item(MODE_BYTE); it.db = 8'h00; it.last = 0; dir.push_back('{it, 0});
      it = rand_item(MODE_BYTE); it.db = 8'hFF; it.last = 0; dir.push_back('{it, 0});
      it = rand_item(MODE_TABLE); it.wt = 0; it.idx = 0; it.st = 0; it.ch = 8'hFF;
      it.ln = 4'hF; dir.push_back('{it, 0});                                 // live rewrite
      it = rand_item(MODE_BYTE); it.db = 8'h80; it.last = 1; dir.push_back('{it, 0});
      it = rand_item(MODE_START); it.dl = 1; dir.push_back('{it, 0});
      it = rand_item(MODE_BYTE); it.db = 8'hFF; it.last = 0; dir.push_back('{it, 0});
      it = rand_item(MODE_BYTE); it.db = 8'h00; it.last = 0; dir.push_back('{it, 0});
      it = rand_item(MODE_BYTE); it.db = 8'h3C; it.last = 1; dir.push_back('{it, 0});
      it = rand_item(MODE_START); it.dl = 3; dir.push_back('{it, 0});
      it = rand_item(MODE_START); it.dl = 2; dir.push_back('{it, 0});       // restart
      it = rand_item(MODE_BYTE); it.db = 8'h5A; it.last = 1; dir.push_back('{it, 0});
      foreach (dir[r]) send_item(dir[r].it, dir[r].nosym_end);
      settle();

      // Random part, phase by phase
      sent = 0;
      for (int p = 0; p < 8; p++) begin
         write_csr(REG_TABLE_SEL, p[0]);
         write_csr(REG_SMALL_CNT, counts[p % 5][1]);
         write_csr(REG_LARGE_CNT, counts[p % 5][2]);
         if (p == 5) write_csr(REG_SMALL_CNT, counts[0][0]);
         send_idle_pct = idle_set[p % 4][0];
         recv_stall_pct = idle_set[p % 4][1];
         if (p == 2) hold_off = 3000;  // long stall to back up the input
         while (sent < (p + 1) * 58) begin
            if ($urandom_range(3) == 0) begin
               send_idle_pct = 0; recv_stall_pct = 0;
            end else begin
               send_idle_pct = idle_set[p % 4][0];
               recv_stall_pct = idle_set[p % 4][1];
            end
            random_text(sent);
         end
         settle();
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
